// File: rtl/cht_pkg.sv
`default_nettype none

package cht_pkg;

    // Field widths of the request and result channels.
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;

    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [VALUE_W-1:0]  value_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Result status codes.
    localparam status_t ST_INSERTED  = 3'd0;
    localparam status_t ST_FOUND     = 3'd1;
    localparam status_t ST_NOT_FOUND = 3'd2;
    localparam status_t ST_FULL      = 3'd3;
    localparam status_t ST_BAD_KEY   = 3'd4;

    // Request commands.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // The home slot comes from a byte fold of the key and a reciprocal multiply.
    // The fold width covers every table size up to 1024 slots.
    localparam int FOLD_W     = 20;
    localparam int MAGIC_W    = FOLD_W + 1;
    localparam int MOD_STAGES = 3;
    localparam int MOD_CNT_W  = 2;

endpackage

`default_nettype wire

// File: rtl/coalesced_hash_table_core.sv
`default_nettype none

// Coalesced hash table: one insert or search request at a time, one result per request.
// A request with key zero goes straight to the result. Otherwise the core finds the home slot through
// the fold and reciprocal stages, follows the chain one slot at a time, scans slot by slot for a free
// one where needed, writes the tail link or reads the value where needed, and then loads the result.
// A new request is taken only in the idle state, entered once the result is loaded; one result waits.
// After reset a clearing pass over every slot empties the table before the first request.
module coalesced_hash_table_core #(
    parameter int SLOTS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_command,
    input  wire logic [cht_pkg::KEY_W-1:0]    s_key,
    input  wire logic [cht_pkg::VALUE_W-1:0]  s_value,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [cht_pkg::STATUS_W-1:0]      m_status,
    output logic [cht_pkg::VALUE_W-1:0]       m_found_value
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW = $clog2(SLOTS + 1);
    localparam int KW = cht_pkg::KEY_W;
    localparam int MW = KW + LW;
    localparam int FW = cht_pkg::FOLD_W;
    localparam int GW = cht_pkg::MAGIC_W;
    localparam int PW = FW + GW;
    localparam int CW = cht_pkg::MOD_CNT_W;

    // Reciprocal of SLOTS, exact for every fold value below 2^FW.
    localparam int     MOD_SH = FW + $clog2(SLOTS);
    localparam longint MAGIC  =
        ((longint'(1) << MOD_SH) + longint'(SLOTS) - 1) / longint'(SLOTS);

    localparam logic [IW-1:0] LAST_IX = IW'(SLOTS - 1);
    localparam logic [LW-1:0] NO_LINK = LW'(SLOTS);
    localparam logic [LW-1:0] SCAN_END = LW'(SLOTS - 1);
    localparam logic [GW-1:0] MAGIC_K = GW'(MAGIC);
    localparam logic [FW-1:0] FOLD_C1 = FW'((1 << 8) % SLOTS);
    localparam logic [FW-1:0] FOLD_C2 = FW'((1 << 16) % SLOTS);
    localparam logic [FW-1:0] FOLD_C3 = FW'((1 << 24) % SLOTS);
    localparam logic [FW-1:0] SLOTS_F = FW'(SLOTS);
    localparam logic [CW-1:0] LAST_MOD = CW'(cht_pkg::MOD_STAGES - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_LINK  = 3'd5;
    localparam logic [2:0] S_VAL   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    // Slot memories: key and link together, value apart.
    logic [MW-1:0]               meta_mem [SLOTS];
    logic [cht_pkg::VALUE_W-1:0] val_mem  [SLOTS];
    logic [MW-1:0]               meta_q;
    logic [cht_pkg::VALUE_W-1:0] val_q;

    logic [2:0]                         state_reg, state_next;
    logic [IW-1:0]                      cur_reg, cur_next;
    logic [LW-1:0]                      steps_reg, steps_next;
    logic [CW-1:0]                      mod_cnt_reg, mod_cnt_next;
    logic [FW-1:0]                      fold_reg, fold_next;
    logic [FW-1:0]                      quot_reg, quot_next;
    logic [IW-1:0]                      tail_reg, tail_next;
    logic [KW-1:0]                      tail_key_reg, tail_key_next;
    logic                               cmd_reg;
    logic [KW-1:0]                      key_reg;
    logic [cht_pkg::VALUE_W-1:0]        val_reg;
    cht_pkg::status_t                   res_status_reg, res_status_next;
    logic [cht_pkg::VALUE_W-1:0]        res_value_reg, res_value_next;
    logic                               m_valid_reg, m_valid_next;
    cht_pkg::status_t                   m_status_reg, m_status_next;
    logic [cht_pkg::VALUE_W-1:0]        m_found_value_reg, m_found_value_next;

    logic                               meta_we;
    logic [IW-1:0]                      meta_wa;
    logic [MW-1:0]                      meta_wd;
    logic                               val_we;
    logic [PW-1:0]                      mod_prod;
    logic [IW-1:0]                      mod_rem;
    logic [IW-1:0]                      cur_wrap;
    logic [KW-1:0]                      meta_key;
    logic [LW-1:0]                      meta_link;
    logic                               link_ok;
    logic                               accept;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_found_value = m_found_value_reg;

    assign meta_key  = meta_q[MW-1:LW];
    assign meta_link = meta_q[LW-1:0];
    assign link_ok   = (meta_link < NO_LINK);
    assign cur_wrap  = (cur_reg == LAST_IX) ? '0 : cur_reg + 1'b1;

    // Home slot, first stage: fold the key bytes with their weights modulo SLOTS.
    assign fold_next = FW'(key_reg[7:0])
                     + FW'(key_reg[15:8])  * FOLD_C1
                     + FW'(key_reg[23:16]) * FOLD_C2
                     + FW'(key_reg[31:24]) * FOLD_C3;

    // Second stage: quotient of the fold by a reciprocal multiply.
    assign mod_prod  = PW'(fold_reg) * PW'(MAGIC_K);
    assign quot_next = FW'(mod_prod >> MOD_SH);

    // Third stage: what is left after the quotient is below SLOTS.
    assign mod_rem   = IW'(fold_reg - quot_reg * SLOTS_F);

    // Sequencer: clear, find home slot, walk chain, scan for a free slot, link or read the value, answer.
    always_comb begin
        state_next         = state_reg;
        cur_next           = cur_reg;
        steps_next         = steps_reg;
        mod_cnt_next       = mod_cnt_reg;
        tail_next          = tail_reg;
        tail_key_next      = tail_key_reg;
        res_status_next    = res_status_reg;
        res_value_next     = res_value_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_status_next      = m_status_reg;
        m_found_value_next = m_found_value_reg;
        meta_we            = 1'b0;
        meta_wa            = cur_reg;
        meta_wd            = {key_reg, NO_LINK};
        val_we             = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                meta_we = 1'b1;
                meta_wd = {{KW{1'b0}}, NO_LINK};
                cur_next = cur_wrap;
                if (cur_reg == LAST_IX) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    mod_cnt_next = '0;
                    steps_next   = '0;
                    if (s_key == '0) begin
                        res_status_next = cht_pkg::ST_BAD_KEY;
                        res_value_next  = '0;
                        state_next      = S_FIN;
                    end else begin
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD: begin
                mod_cnt_next = mod_cnt_reg + 1'b1;
                if (mod_cnt_reg == LAST_MOD) begin
                    cur_next   = mod_rem;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                res_value_next = '0;
                if (cmd_reg == cht_pkg::CMD_INSERT) begin
                    if (meta_key == '0) begin
                        // Empty home slot takes the entry directly.
                        meta_we         = 1'b1;
                        val_we          = 1'b1;
                        res_status_next = cht_pkg::ST_INSERTED;
                        state_next      = S_FIN;
                    end else if (link_ok && (steps_reg < NO_LINK)) begin
                        cur_next   = meta_link[IW-1:0];
                        steps_next = steps_reg + 1'b1;
                    end else begin
                        // Tail reached: remember it and scan from the next slot.
                        tail_next     = cur_reg;
                        tail_key_next = meta_key;
                        cur_next      = cur_wrap;
                        steps_next    = LW'(1);
                        state_next    = S_SCAN;
                    end
                end else begin
                    if (meta_key == key_reg) begin
                        state_next = S_VAL;
                    end else if (!link_ok || (steps_reg == NO_LINK)) begin
                        res_status_next = cht_pkg::ST_NOT_FOUND;
                        state_next      = S_FIN;
                    end else begin
                        cur_next   = meta_link[IW-1:0];
                        steps_next = steps_reg + 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (meta_key == '0) begin
                    meta_we    = 1'b1;
                    val_we     = 1'b1;
                    state_next = S_LINK;
                end else if (steps_reg == SCAN_END) begin
                    res_status_next = cht_pkg::ST_FULL;
                    state_next      = S_FIN;
                end else begin
                    steps_next = steps_reg + 1'b1;
                    cur_next   = cur_wrap;
                end
            end
            S_LINK: begin
                // Point the old tail at the new entry.
                meta_we         = 1'b1;
                meta_wa         = tail_reg;
                meta_wd         = {tail_key_reg, LW'(cur_reg)};
                res_status_next = cht_pkg::ST_INSERTED;
                state_next      = S_FIN;
            end
            S_VAL: begin
                res_status_next = cht_pkg::ST_FOUND;
                res_value_next  = val_q;
                state_next      = S_FIN;
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_status_next      = res_status_reg;
                    m_found_value_next = res_value_reg;
                    state_next         = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cur_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        steps_reg         <= steps_next;
        mod_cnt_reg       <= mod_cnt_next;
        fold_reg          <= fold_next;
        quot_reg          <= quot_next;
        tail_reg          <= tail_next;
        tail_key_reg      <= tail_key_next;
        res_status_reg    <= res_status_next;
        res_value_reg     <= res_value_next;
        m_status_reg      <= m_status_next;
        m_found_value_reg <= m_found_value_next;
        if (accept) begin
            cmd_reg <= s_command;
            key_reg <= s_key;
            val_reg <= s_value;
        end
    end

    // Metadata memory: the read follows the slot the sequencer moves to.
    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[meta_wa] <= meta_wd;
        end
        meta_q <= meta_mem[cur_next];
    end

    // Value memory: written on insert, read at the matching slot.
    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[cur_reg] <= val_reg;
        end
        val_q <= val_mem[cur_reg];
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == S_IDLE) && !meta_we)
        else $error("request taken while the table is busy");

    a_bad_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_key == '0)) |=>
            (state_reg == S_FIN) && (res_status_reg == cht_pkg::ST_BAD_KEY))
        else $error("zero key not rejected at once");

    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != cht_pkg::ST_FOUND)) |-> (m_found_value == '0))
        else $error("nonzero value on a result that is not a hit");

    a_link_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LINK) |-> ($past(state_reg) == S_SCAN) && ($past(meta_key) == '0))
        else $error("tail linked without a free slot");
`endif

endmodule

`default_nettype wire

// File: dv/cht_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the hash table, keeps a shadow copy of the table,
// and compares every result with the outcome predicted for its request.
module cht_checker #(
    parameter int SLOTS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    input  wire logic                         s_ready,
    input  wire logic                         s_command,
    input  wire logic [cht_pkg::KEY_W-1:0]    s_key,
    input  wire logic [cht_pkg::VALUE_W-1:0]  s_value,
    input  wire logic                         m_valid,
    input  wire logic                         m_ready,
    input  wire logic [cht_pkg::STATUS_W-1:0] m_status,
    input  wire logic [cht_pkg::VALUE_W-1:0]  m_found_value,
    output int                                fail_count,
    output int                                pending
);

    localparam int LINK_W = $clog2(SLOTS) + 1;

    typedef struct packed {
        cht_pkg::status_t status;
        cht_pkg::value_t  found_value;
    } outcome_t;

    // Shadow table: keys (zero means empty), payloads and chain links.
    cht_pkg::key_t     shadow_key  [SLOTS];
    cht_pkg::value_t   shadow_val  [SLOTS];
    logic [LINK_W-1:0] shadow_next [SLOTS];

    // Outcomes of accepted requests whose results have not come yet.
    outcome_t outcomes_due [$];

    // Applies one request to the shadow table and returns its outcome.
    function automatic outcome_t apply_request(logic cmd, cht_pkg::key_t key,
                                               cht_pkg::value_t value);
        outcome_t    res;
        int unsigned home;
        int unsigned cur;
        int unsigned pos;
        int unsigned steps;
        res.status      = cht_pkg::ST_NOT_FOUND;
        res.found_value = '0;
        home            = key % SLOTS;
        if (key == '0) begin
            res.status = cht_pkg::ST_BAD_KEY;
        end else if (cmd == cht_pkg::CMD_INSERT) begin
            if (shadow_key[home] == '0) begin
                shadow_key[home]  = key;
                shadow_val[home]  = value;
                shadow_next[home] = LINK_W'(SLOTS);
                res.status        = cht_pkg::ST_INSERTED;
            end else begin
                // Walk to the tail of the chain through the home slot.
                cur   = home;
                steps = 0;
                while (steps < SLOTS && shadow_next[cur] < SLOTS) begin
                    cur = 32'(shadow_next[cur]);
                    steps++;
                end
                // Scan forward from the tail, wrapping, for the first empty slot.
                res.status = cht_pkg::ST_FULL;
                pos        = cur;
                for (int i = 1; i < SLOTS; i++) begin
                    pos = (pos + 1) % SLOTS;
                    if (shadow_key[pos] == '0) begin
                        shadow_key[pos]  = key;
                        shadow_val[pos]  = value;
                        shadow_next[pos] = LINK_W'(SLOTS);
                        shadow_next[cur] = LINK_W'(pos);
                        res.status       = cht_pkg::ST_INSERTED;
                        break;
                    end
                end
            end
        end else begin
            // Follow the chain from the home slot until a key matches or it ends.
            cur = home;
            for (steps = 0; steps <= SLOTS; steps++) begin
                if (shadow_key[cur] == key) begin
                    res.status      = cht_pkg::ST_FOUND;
                    res.found_value = shadow_val[cur];
                    break;
                end
                if (shadow_next[cur] >= SLOTS) begin
                    break;
                end
                cur = 32'(shadow_next[cur]);
            end
        end
        return res;
    endfunction

    // Results are checked before a request of the same edge is predicted, since
    // a result always belongs to an earlier request.
    always @(posedge aclk) begin : monitor
        outcome_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                shadow_key[i]  = '0;
                shadow_val[i]  = '0;
                shadow_next[i] = LINK_W'(SLOTS);
            end
            outcomes_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (outcomes_due.size() == 0) begin
                    $error("result with no request outstanding: status %0d, found_value 0x%08h",
                           m_status, m_found_value);
                    fail_count++;
                end else begin
                    want = outcomes_due.pop_front();
                    if (m_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_status);
                        fail_count++;
                    end
                    if (m_found_value !== want.found_value) begin
                        $error("found_value mismatch: expected 0x%08h, actual 0x%08h",
                               want.found_value, m_found_value);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                outcomes_due.push_back(apply_request(s_command, s_key, s_value));
            end
        end
        pending = outcomes_due.size();
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the coalesced hash table core.
module tb;

    localparam int SLOTS          = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 350;
    localparam int PRESSURE_ITEMS = 50;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_command = cht_pkg::CMD_INSERT;
    cht_pkg::key_t    s_key     = '0;
    cht_pkg::value_t  s_value   = '0;
    logic             m_ready   = 1'b0;
    logic             s_ready;
    logic             m_valid;
    cht_pkg::status_t m_status;
    cht_pkg::value_t  m_found_value;

    int fail_count;
    int pending;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    bit hold_req       = 1'b0;
    int idle_cycles    = 0;

    // Keys of all insert requests with a nonzero key sent so far, reused to aim searches at hits.
    cht_pkg::key_t inserted_keys [$];

    always #2 aclk = ~aclk;

    coalesced_hash_table_core #(
        .SLOTS(SLOTS)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_key        (s_key),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_found_value(m_found_value)
    );

    cht_checker #(
        .SLOTS(SLOTS)
    ) i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_key        (s_key),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_found_value(m_found_value),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Result side: random stalls, or a long hold-off when one is requested.
    initial begin : sink_drive
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // The run is stuck when no request and no result moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Offers one request, idling first at random, and returns once it is taken.
    task automatic send_request(input logic cmd, input cht_pkg::key_t key,
                                input cht_pkg::value_t value);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_key     <= key;
        s_value   <= value;
        if (cmd == cht_pkg::CMD_INSERT && key != '0) begin
            inserted_keys.push_back(key);
        end
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // Stops offering and waits until every outstanding result has arrived.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending == 0);
    endtask

    // Mix of earlier keys, keys sharing a home slot with them, zero and random keys.
    function automatic cht_pkg::key_t pick_key();
        int            r;
        cht_pkg::key_t k;
        r = $urandom_range(99);
        if (r < 3) begin
            return '0;
        end
        if (inserted_keys.size() == 0 || r >= 75) begin
            return $urandom();
        end
        k = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
        if (r < 50) begin
            return k;
        end
        return {28'($urandom_range(32'h0FFF_FFFF, 0)), k[3:0]};
    endfunction

    task automatic random_phase(input int n, input int src_pct, input int sink_pct);
        logic cmd;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        repeat (n) begin
            cmd = ($urandom_range(99) < 30) ? cht_pkg::CMD_INSERT : cht_pkg::CMD_SEARCH;
            send_request(cmd, pick_key(), $urandom());
        end
        drain();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Key zero is rejected for both commands.
        send_request(cht_pkg::CMD_SEARCH, '0, 32'hFFFF_FFFF);
        send_request(cht_pkg::CMD_INSERT, '0, 32'h1234_5678);
        // Search on an empty home slot.
        send_request(cht_pkg::CMD_SEARCH, 32'h0000_0005, '0);
        // Home slot insert, then a collision and a chain that coalesces into it.
        send_request(cht_pkg::CMD_INSERT, 32'h0000_0011, 32'hFFFF_FFFF);
        send_request(cht_pkg::CMD_INSERT, 32'h0000_0021, 32'hA5A5_0021);
        send_request(cht_pkg::CMD_INSERT, 32'h0000_0002, 32'h0000_0002);
        // Top slot taken, so the next key of that home wraps to slot zero.
        send_request(cht_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(cht_pkg::CMD_INSERT, 32'h0000_001F, 32'h5A5A_001F);
        // A duplicate key goes to the chain's end; search returns the first one.
        send_request(cht_pkg::CMD_INSERT, 32'h0000_0011, 32'h0BAD_0011);
        send_request(cht_pkg::CMD_SEARCH, 32'h0000_0011, 32'hFFFF_FFFF);
        send_request(cht_pkg::CMD_SEARCH, 32'h0000_0021, '0);
        // Miss at the end of a chain, then a hit through the wrapped link.
        send_request(cht_pkg::CMD_SEARCH, 32'h0000_0031, '0);
        send_request(cht_pkg::CMD_SEARCH, 32'h0000_001F, '0);
        // Fill the table through one long chain, then overflow it.
        for (int k = 3; k < 13; k++) begin
            send_request(cht_pkg::CMD_INSERT, cht_pkg::key_t'(k * 16 + 1), $urandom());
        end
        send_request(cht_pkg::CMD_INSERT, 32'h8000_0001, $urandom());
        send_request(cht_pkg::CMD_SEARCH, 32'hFFFF_FFFF, '0);
        drain();

        random_phase(PHASE_ITEMS, 0, 0);
        random_phase(PHASE_ITEMS, 88, 0);
        random_phase(PHASE_ITEMS, 0, 88);
        random_phase(PHASE_ITEMS, 7, 7);

        // The result side holds off while requests keep coming, so the core backs up.
        hold_req = 1'b1;
        random_phase(PRESSURE_ITEMS, 0, 0);

        repeat (64) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
